// ===== rtl/drp_pkg.sv =====
// ----------------------------------------------------------------------------
// DHCP reply parser package
// Payload structs, status codes, option codes and header layout constants.
// ----------------------------------------------------------------------------
package drp_pkg;

   localparam int OFFSET_LIMIT = 2047;
   localparam int OFFSET_W     = $clog2(OFFSET_LIMIT + 1);

   typedef logic [OFFSET_W-1:0] offset_type;

   // Fixed header layout, in byte positions from the start of the payload.
   localparam int HDR_LEN       = 240;
   localparam int POS_OP        = 0;
   localparam int POS_XID_FIRST = 4;
   localparam int POS_XID_LAST  = 7;
   localparam int POS_YI_FIRST  = 16;
   localparam int POS_YI_LAST   = 19;
   localparam int POS_HW_FIRST  = 28;
   localparam int POS_HW_LAST   = 33;
   localparam int POS_CK_FIRST  = 236;
   localparam int POS_CK_LAST   = 239;

   localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
   localparam logic [31:0] XID_RESET    = 32'h5041_4b4f;
   localparam logic [7:0]  OP_REPLY     = 8'd2;

   localparam logic [7:0] OPT_PAD     = 8'h00;
   localparam logic [7:0] OPT_END     = 8'hff;
   localparam logic [7:0] OPT_MASK    = 8'd1;
   localparam logic [7:0] OPT_ROUTER  = 8'd3;
   localparam logic [7:0] OPT_LEASE   = 8'd51;
   localparam logic [7:0] OPT_MSGTYPE = 8'd53;
   localparam logic [7:0] OPT_SERVER  = 8'd54;

   // Option walk states.
   localparam logic [1:0] PH_CODE = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_NOT_REPLY  = 3'd1;
   localparam logic [2:0] STATUS_XID        = 3'd2;
   localparam logic [2:0] STATUS_HW_ADDR    = 3'd3;
   localparam logic [2:0] STATUS_COOKIE     = 3'd4;
   localparam logic [2:0] STATUS_NO_MSGTYPE = 3'd5;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd6;

   localparam logic CSR_CLIENT_MAC = 1'b0;
   localparam logic CSR_XID        = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  msg_type;
      logic [31:0] offered_addr;
      logic [31:0] router_addr;
      logic [31:0] subnet_mask;
      logic [31:0] server_addr;
      logic [31:0] lease_seconds;
   } rsp_type;

endpackage

// ===== rtl/dhcp_reply_parser.sv =====
// ----------------------------------------------------------------------------
// DHCP reply parser
// Checks the fixed header of a DHCP reply byte by byte, walks the option
// list and reports a status with the captured lease parameters.
// ----------------------------------------------------------------------------
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    data_byte, last_byte
//   rsp_      out         rsp_valid/rsp_ready    status and captured values
//   csr_      in          csr_write              csr_index, csr_wdata (48 bits)
//
// One byte per cycle is accepted. Each request is registered in the input
// register and processed from there; a last byte's response is registered
// in the output register. A last byte waits in the input register while an
// earlier response is not taken; other bytes never stall. Reset is synchronous
// and restores the register defaults and clears all captured values.
// ----------------------------------------------------------------------------
module dhcp_reply_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  drp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output drp_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [47:0]       csr_wdata
);

   logic              in_valid_ff;
   drp_pkg::req_type  in_data_ff;
   logic              in_advance;

   logic [47:0] mac_ff;
   logic [31:0] xid_ff;

   drp_pkg::offset_type offset_ff, offset_in;
   logic [2:0]  hdr_status_ff, hdr_status_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [31:0] capture_ff, capture_in;
   logic        end_seen_ff, end_seen_in;
   logic [7:0]  msg_type_ff, msg_type_in;
   logic [31:0] offer_ff, offer_in;
   logic [31:0] router_ff, router_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] server_ff, server_in;
   logic [31:0] lease_ff, lease_in;

   logic              rsp_valid_ff;
   drp_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [7:0]  b;
   logic [7:0]  xid_byte, mac_byte, cookie_byte;
   logic [2:0]  fail;
   logic [7:0]  count_next;

   // A non-final byte produces no response, so it never waits on the output.
   assign in_advance = in_valid_ff && (!in_data_ff.last_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || in_advance;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign b          = in_data_ff.data_byte;

   always_comb begin
      unique case (offset_ff[1:0])
         2'd0: xid_byte = xid_ff[31:24];
         2'd1: xid_byte = xid_ff[23:16];
         2'd2: xid_byte = xid_ff[15:8];
         2'd3: xid_byte = xid_ff[7:0];
      endcase
      unique case (offset_ff[1:0])
         2'd0: cookie_byte = drp_pkg::MAGIC_COOKIE[31:24];
         2'd1: cookie_byte = drp_pkg::MAGIC_COOKIE[23:16];
         2'd2: cookie_byte = drp_pkg::MAGIC_COOKIE[15:8];
         2'd3: cookie_byte = drp_pkg::MAGIC_COOKIE[7:0];
      endcase
      unique case (offset_ff[5:0])
         6'd28:   mac_byte = mac_ff[47:40];
         6'd29:   mac_byte = mac_ff[39:32];
         6'd30:   mac_byte = mac_ff[31:24];
         6'd31:   mac_byte = mac_ff[23:16];
         6'd32:   mac_byte = mac_ff[15:8];
         default: mac_byte = mac_ff[7:0];
      endcase
   end

   always_comb begin
      offset_in     = offset_ff;
      hdr_status_in = hdr_status_ff;
      phase_in      = phase_ff;
      code_in       = code_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      capture_in    = capture_ff;
      end_seen_in   = end_seen_ff;
      msg_type_in   = msg_type_ff;
      offer_in      = offer_ff;
      router_in     = router_ff;
      mask_in       = mask_ff;
      server_in     = server_ff;
      lease_in      = lease_ff;
      rsp_data_in   = rsp_data_ff;
      fail          = drp_pkg::STATUS_OK;
      count_next    = count_ff + 8'd1;

      if (in_advance) begin
         if (offset_ff < drp_pkg::offset_type'(drp_pkg::HDR_LEN)) begin
            priority if (offset_ff == drp_pkg::offset_type'(drp_pkg::POS_OP)) begin
               if (b != drp_pkg::OP_REPLY) fail = drp_pkg::STATUS_NOT_REPLY;
            end else if (offset_ff >= drp_pkg::offset_type'(drp_pkg::POS_XID_FIRST) &&
                         offset_ff <= drp_pkg::offset_type'(drp_pkg::POS_XID_LAST)) begin
               if (b != xid_byte) fail = drp_pkg::STATUS_XID;
            end else if (offset_ff >= drp_pkg::offset_type'(drp_pkg::POS_YI_FIRST) &&
                         offset_ff <= drp_pkg::offset_type'(drp_pkg::POS_YI_LAST)) begin
               capture_in = {capture_ff[23:0], b};
            end else if (offset_ff >= drp_pkg::offset_type'(drp_pkg::POS_HW_FIRST) &&
                         offset_ff <= drp_pkg::offset_type'(drp_pkg::POS_HW_LAST)) begin
               if (b != mac_byte) fail = drp_pkg::STATUS_HW_ADDR;
            end else if (offset_ff >= drp_pkg::offset_type'(drp_pkg::POS_CK_FIRST)) begin
               if (b != cookie_byte) fail = drp_pkg::STATUS_COOKIE;
            end
            // Only the first failing check is reported.
            if (hdr_status_ff == drp_pkg::STATUS_OK) hdr_status_in = fail;
            if (offset_ff == drp_pkg::offset_type'(drp_pkg::POS_CK_LAST) &&
                hdr_status_in == drp_pkg::STATUS_OK) begin
               offer_in = capture_ff;
            end
         end else if (hdr_status_ff == drp_pkg::STATUS_OK && !end_seen_ff) begin
            unique case (phase_ff)
               drp_pkg::PH_CODE: begin
                  if (b == drp_pkg::OPT_END) begin
                     end_seen_in = 1'b1;
                  end else if (b != drp_pkg::OPT_PAD) begin
                     code_in  = b;
                     phase_in = drp_pkg::PH_LEN;
                  end
               end
               drp_pkg::PH_LEN: begin
                  length_in  = b;
                  count_in   = 8'd0;
                  capture_in = 32'd0;
                  phase_in   = (b == 8'd0) ? drp_pkg::PH_CODE : drp_pkg::PH_DATA;
               end
               drp_pkg::PH_DATA: begin
                  if (count_ff < 8'd4) capture_in = {capture_ff[23:0], b};
                  count_in = count_next;
                  if (count_next == 8'd1 && code_ff == drp_pkg::OPT_MSGTYPE &&
                      length_ff == 8'd1) begin
                     msg_type_in = b;
                  end
                  if (count_next == 8'd4) begin
                     priority if (code_ff == drp_pkg::OPT_ROUTER && length_ff >= 8'd4)
                        router_in = capture_in;
                     else if (code_ff == drp_pkg::OPT_MASK && length_ff == 8'd4)
                        mask_in = capture_in;
                     else if (code_ff == drp_pkg::OPT_SERVER && length_ff == 8'd4)
                        server_in = capture_in;
                     else if (code_ff == drp_pkg::OPT_LEASE && length_ff == 8'd4)
                        lease_in = capture_in;
                  end
                  if (count_next >= length_ff) phase_in = drp_pkg::PH_CODE;
               end
               default: phase_in = drp_pkg::PH_CODE;
            endcase
         end

         if (offset_ff < drp_pkg::offset_type'(drp_pkg::OFFSET_LIMIT))
            offset_in = offset_ff + drp_pkg::offset_type'(1);

         if (in_data_ff.last_byte) begin
            priority if (hdr_status_in != drp_pkg::STATUS_OK)
               rsp_data_in.status = hdr_status_in;
            else if (offset_ff < drp_pkg::offset_type'(drp_pkg::POS_CK_LAST))
               rsp_data_in.status = drp_pkg::STATUS_TRUNCATED;
            else if (!end_seen_in)
               rsp_data_in.status = drp_pkg::STATUS_TRUNCATED;
            else if (msg_type_in == 8'd0)
               rsp_data_in.status = drp_pkg::STATUS_NO_MSGTYPE;
            else
               rsp_data_in.status = drp_pkg::STATUS_OK;
            rsp_data_in.msg_type      = msg_type_in;
            rsp_data_in.offered_addr  = offer_in;
            rsp_data_in.router_addr   = router_in;
            rsp_data_in.subnet_mask   = mask_in;
            rsp_data_in.server_addr   = server_in;
            rsp_data_in.lease_seconds = lease_in;

            // Start the next datagram from a clean walk.
            offset_in     = '0;
            hdr_status_in = drp_pkg::STATUS_OK;
            phase_in      = drp_pkg::PH_CODE;
            code_in       = 8'd0;
            length_in     = 8'd0;
            count_in      = 8'd0;
            capture_in    = 32'd0;
            end_seen_in   = 1'b0;
            msg_type_in   = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mac_ff        <= 48'd0;
         xid_ff        <= drp_pkg::XID_RESET;
         offset_ff     <= '0;
         hdr_status_ff <= drp_pkg::STATUS_OK;
         phase_ff      <= drp_pkg::PH_CODE;
         code_ff       <= 8'd0;
         length_ff     <= 8'd0;
         count_ff      <= 8'd0;
         capture_ff    <= 32'd0;
         end_seen_ff   <= 1'b0;
         msg_type_ff   <= 8'd0;
         offer_ff      <= 32'd0;
         router_ff     <= 32'd0;
         mask_ff       <= 32'd0;
         server_ff     <= 32'd0;
         lease_ff      <= 32'd0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (in_advance && in_data_ff.last_byte) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               drp_pkg::CSR_CLIENT_MAC: mac_ff <= csr_wdata;
               drp_pkg::CSR_XID:        xid_ff <= csr_wdata[31:0];
            endcase
         end
         offset_ff     <= offset_in;
         hdr_status_ff <= hdr_status_in;
         phase_ff      <= phase_in;
         code_ff       <= code_in;
         length_ff     <= length_in;
         count_ff      <= count_in;
         capture_ff    <= capture_in;
         end_seen_ff   <= end_seen_in;
         msg_type_ff   <= msg_type_in;
         offer_ff      <= offer_in;
         router_ff     <= router_in;
         mask_ff       <= mask_in;
         server_ff     <= server_in;
         lease_ff      <= lease_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_data_ff <= req_data;
      rsp_data_ff <= rsp_data_in;
   end

   // A final byte always leaves a response and a rewound offset behind.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      in_advance && in_data_ff.last_byte |=> rsp_valid_ff && offset_ff == '0)
      else $error("final byte did not produce a response");

   // An ok status is never reported without a message type.
   a_ok_has_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == drp_pkg::STATUS_OK |-> rsp_data_ff.msg_type != 8'd0)
      else $error("ok status with no message type");

   // Within an option's data the byte count stays below the length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == drp_pkg::PH_DATA |-> count_ff < length_ff)
      else $error("option byte count overran its length");

   // Options are never walked once the header has failed.
   a_fail_no_walk: assert property (@(posedge clock) disable iff (reset)
      hdr_status_ff != drp_pkg::STATUS_OK |-> !end_seen_ff && phase_ff == drp_pkg::PH_CODE)
      else $error("option walk active after header failure");

   // A final byte waiting on an untaken response holds off new requests.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_data_ff.last_byte && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while a response stalls");

endmodule

// ===== tb/dhcp_reply_parser_tb.sv =====
// ----------------------------------------------------------------------------
// DHCP reply parser testbench
// Sends whole datagrams byte by byte: a table of directed datagrams first,
// then random well-formed, broken and noise datagrams under several register
// settings. Every response is checked against a cycle-free parser model.
// ----------------------------------------------------------------------------
module dhcp_reply_parser_tb;
   import drp_pkg::*;

   localparam int DRAIN_CYCLES = 6;
   localparam int RUN_LIMIT    = 2000000;

   typedef enum logic [3:0] {
      PLAN_FULL, PLAN_END_ONLY, PLAN_MSG_ZERO, PLAN_NO_END, PLAN_CUT_DATA,
      PLAN_CUT_LEN, PLAN_ODD, PLAN_REPEAT, PLAN_RANDOM
   } opt_plan_e;

   typedef enum {TAKE_ALL, TAKE_COIN, TAKE_PATTERN} take_mode_e;

   typedef struct packed {
      opt_plan_e   plan;
      logic [7:0]  op;
      logic        bad_xid;
      logic        bad_hw;
      logic        bad_ck;
      logic [15:0] cut;
      logic [15:0] tail;
      logic        typed;
      logic [2:0]  want;
   } row_t;

   typedef struct packed {
      rsp_type    val;
      logic       typed;
      logic [2:0] want;
   } reply_due_t;

   // A cut of zero keeps the datagram at its natural length.
   localparam row_t DIRECTED_ROWS [21] = '{
      '{PLAN_FULL,     OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd0,   16'd0,    1'b1, STATUS_OK},
      '{PLAN_FULL,     8'd1,     1'b0, 1'b0, 1'b0, 16'd1,   16'd0,    1'b1, STATUS_NOT_REPLY},
      '{PLAN_FULL,     8'hff,    1'b1, 1'b0, 1'b0, 16'd240, 16'd0,    1'b1, STATUS_NOT_REPLY},
      '{PLAN_FULL,     8'h00,    1'b0, 1'b0, 1'b0, 16'd1,   16'd0,    1'b1, STATUS_NOT_REPLY},
      '{PLAN_FULL,     OP_REPLY, 1'b1, 1'b0, 1'b0, 16'd0,   16'd0,    1'b1, STATUS_XID},
      '{PLAN_FULL,     OP_REPLY, 1'b1, 1'b0, 1'b1, 16'd10,  16'd0,    1'b1, STATUS_XID},
      '{PLAN_FULL,     OP_REPLY, 1'b0, 1'b1, 1'b0, 16'd0,   16'd0,    1'b1, STATUS_HW_ADDR},
      '{PLAN_FULL,     OP_REPLY, 1'b0, 1'b1, 1'b1, 16'd0,   16'd0,    1'b1, STATUS_HW_ADDR},
      '{PLAN_FULL,     OP_REPLY, 1'b0, 1'b0, 1'b1, 16'd0,   16'd0,    1'b1, STATUS_COOKIE},
      '{PLAN_END_ONLY, OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd0,   16'd0,    1'b1, STATUS_NO_MSGTYPE},
      '{PLAN_MSG_ZERO, OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd0,   16'd0,    1'b1, STATUS_NO_MSGTYPE},
      '{PLAN_FULL,     OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd100, 16'd0,    1'b1, STATUS_TRUNCATED},
      '{PLAN_FULL,     OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd239, 16'd0,    1'b1, STATUS_TRUNCATED},
      '{PLAN_FULL,     OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd240, 16'd0,    1'b1, STATUS_TRUNCATED},
      '{PLAN_NO_END,   OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd0,   16'd0,    1'b1, STATUS_TRUNCATED},
      '{PLAN_CUT_DATA, OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd0,   16'd0,    1'b1, STATUS_TRUNCATED},
      '{PLAN_CUT_LEN,  OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd0,   16'd0,    1'b1, STATUS_TRUNCATED},
      '{PLAN_ODD,      OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd0,   16'd5,    1'b0, STATUS_OK},
      '{PLAN_REPEAT,   OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd0,   16'd0,    1'b0, STATUS_OK},
      '{PLAN_FULL,     OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd0,   16'd1900, 1'b0, STATUS_OK},
      '{PLAN_FULL,     OP_REPLY, 1'b0, 1'b0, 1'b0, 16'd0,   16'd0,    1'b0, STATUS_OK}
   };

   localparam logic [7:0] KNOWN_CODES [5] = '{
      OPT_MASK, OPT_ROUTER, OPT_LEASE, OPT_MSGTYPE, OPT_SERVER
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_write;
   logic        csr_index;
   logic [47:0] csr_wdata;

   // Parser model state.
   logic [47:0] cfg_mac;
   logic [31:0] cfg_xid;
   offset_type  dg_offset;
   logic [2:0]  hdr_fault;
   logic [1:0]  walk_phase;
   logic [7:0]  opt_code;
   logic [7:0]  opt_len;
   logic [7:0]  opt_seen;
   logic [31:0] gather;
   logic        end_found;
   logic [7:0]  k_msg;
   logic [31:0] k_offer;
   logic [31:0] k_router;
   logic [31:0] k_mask;
   logic [31:0] k_server;
   logic [31:0] k_lease;

   reply_due_t  replies_due [$];
   logic [7:0]  frame [$];
   logic        row_typed;
   logic [2:0]  row_want;
   int          burst_left;
   int          mismatches;

   dhcp_reply_parser dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic void new_datagram();
      dg_offset  = '0;
      hdr_fault  = STATUS_OK;
      walk_phase = PH_CODE;
      opt_code   = '0;
      opt_len    = '0;
      opt_seen   = '0;
      gather     = '0;
      end_found  = 1'b0;
      k_msg      = '0;
   endfunction

   function automatic void first_fault(logic [2:0] code);
      if (hdr_fault == STATUS_OK) hdr_fault = code;
   endfunction

   function automatic void parse_byte(req_type r);
      int         p;
      logic [7:0] b;
      reply_due_t due;
      p = int'(dg_offset);
      b = r.data_byte;
      if (p < HDR_LEN) begin
         if (p == POS_OP) begin
            if (b != OP_REPLY) first_fault(STATUS_NOT_REPLY);
         end else if (p >= POS_XID_FIRST && p <= POS_XID_LAST) begin
            if (b != cfg_xid[8*(POS_XID_LAST-p) +: 8]) first_fault(STATUS_XID);
         end else if (p >= POS_YI_FIRST && p <= POS_YI_LAST) begin
            gather = {gather[23:0], b};
         end else if (p >= POS_HW_FIRST && p <= POS_HW_LAST) begin
            if (b != cfg_mac[8*(POS_HW_LAST-p) +: 8]) first_fault(STATUS_HW_ADDR);
         end else if (p >= POS_CK_FIRST && p <= POS_CK_LAST) begin
            if (b != MAGIC_COOKIE[8*(POS_CK_LAST-p) +: 8]) first_fault(STATUS_COOKIE);
            if (p == POS_CK_LAST && hdr_fault == STATUS_OK) k_offer = gather;
         end
      end else if (hdr_fault == STATUS_OK && !end_found) begin
         case (walk_phase)
            PH_CODE: begin
               if (b == OPT_END) begin
                  end_found = 1'b1;
               end else if (b != OPT_PAD) begin
                  opt_code   = b;
                  walk_phase = PH_LEN;
               end
            end
            PH_LEN: begin
               opt_len    = b;
               opt_seen   = '0;
               gather     = '0;
               walk_phase = (b == 8'd0) ? PH_CODE : PH_DATA;
            end
            default: begin
               if (opt_seen < 8'd4) gather = {gather[23:0], b};
               opt_seen++;
               if (opt_seen == 8'd1 && opt_code == OPT_MSGTYPE && opt_len == 8'd1) k_msg = b;
               // Values are taken only once four data bytes have arrived.
               if (opt_seen == 8'd4) begin
                  if (opt_code == OPT_ROUTER && opt_len >= 8'd4) k_router = gather;
                  else if (opt_code == OPT_MASK && opt_len == 8'd4) k_mask = gather;
                  else if (opt_code == OPT_SERVER && opt_len == 8'd4) k_server = gather;
                  else if (opt_code == OPT_LEASE && opt_len == 8'd4) k_lease = gather;
               end
               if (opt_seen >= opt_len) walk_phase = PH_CODE;
            end
         endcase
      end
      if (dg_offset < OFFSET_LIMIT) dg_offset++;
      if (r.last_byte) begin
         if (hdr_fault != STATUS_OK) due.val.status = hdr_fault;
         else if (p < HDR_LEN - 1 || !end_found) due.val.status = STATUS_TRUNCATED;
         else if (k_msg == 8'd0) due.val.status = STATUS_NO_MSGTYPE;
         else due.val.status = STATUS_OK;
         due.val.msg_type      = k_msg;
         due.val.offered_addr  = k_offer;
         due.val.router_addr   = k_router;
         due.val.subnet_mask   = k_mask;
         due.val.server_addr   = k_server;
         due.val.lease_seconds = k_lease;
         due.typed = row_typed;
         due.want  = row_want;
         replies_due.push_back(due);
         new_datagram();
      end
   endfunction

   // ------------------------------------------------------------- checking

   function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s at %0t: expected %h, got %h", field, $time, want, got);
   endfunction

   function automatic void check_reply(rsp_type got);
      reply_due_t due;
      if (replies_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("response with none pending at %0t: %h", $time, got);
      end else begin
         due = replies_due.pop_front();
         if (due.typed && got.status !== due.want)
            note_mismatch("directed status", 32'(due.want), 32'(got.status));
         if (got.status !== due.val.status)
            note_mismatch("status", 32'(due.val.status), 32'(got.status));
         if (got.msg_type !== due.val.msg_type)
            note_mismatch("msg_type", 32'(due.val.msg_type), 32'(got.msg_type));
         if (got.offered_addr !== due.val.offered_addr)
            note_mismatch("offered_addr", due.val.offered_addr, got.offered_addr);
         if (got.router_addr !== due.val.router_addr)
            note_mismatch("router_addr", due.val.router_addr, got.router_addr);
         if (got.subnet_mask !== due.val.subnet_mask)
            note_mismatch("subnet_mask", due.val.subnet_mask, got.subnet_mask);
         if (got.server_addr !== due.val.server_addr)
            note_mismatch("server_addr", due.val.server_addr, got.server_addr);
         if (got.lease_seconds !== due.val.lease_seconds)
            note_mismatch("lease_seconds", due.val.lease_seconds, got.lease_seconds);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) parse_byte(req_data);
         if (rsp_valid && rsp_ready) check_reply(rsp_data);
      end
   end

   // ------------------------------------------------------ datagram builder

   function automatic void build_header(logic [7:0] op, logic bad_xid, logic bad_hw,
                                        logic bad_ck);
      frame.delete();
      for (int i = 0; i < HDR_LEN; i++) frame.push_back(8'($urandom));
      frame[POS_OP] = op;
      for (int i = 0; i < 4; i++) frame[POS_XID_FIRST + i] = cfg_xid[31-8*i -: 8];
      for (int i = 0; i < 6; i++) frame[POS_HW_FIRST + i] = cfg_mac[47-8*i -: 8];
      for (int i = 0; i < 4; i++) frame[POS_CK_FIRST + i] = MAGIC_COOKIE[31-8*i -: 8];
      if (bad_xid) frame[POS_XID_FIRST + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
      if (bad_hw) frame[POS_HW_FIRST + $urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
      if (bad_ck) frame[POS_CK_FIRST + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
   endfunction

   function automatic void put_opt(logic [7:0] code, logic [7:0] len, logic [31:0] val);
      frame.push_back(code);
      frame.push_back(len);
      for (int k = 0; k < len; k++) frame.push_back(k < 4 ? val[31-8*k -: 8] : 8'($urandom));
   endfunction

   function automatic void add_plan(opt_plan_e plan);
      logic [7:0] mt;
      case (plan)
         PLAN_FULL: begin
            put_opt(OPT_MSGTYPE, 8'd1, {8'($urandom_range(1, 8)), 24'h0});
            put_opt(OPT_MASK, 8'd4, $urandom);
            put_opt(OPT_ROUTER, 8'd4, $urandom);
            put_opt(OPT_SERVER, 8'd4, $urandom);
            put_opt(OPT_LEASE, 8'd4, $urandom);
            frame.push_back(OPT_END);
         end
         PLAN_END_ONLY: frame.push_back(OPT_END);
         PLAN_MSG_ZERO: begin
            put_opt(OPT_MSGTYPE, 8'd1, 32'h0);
            frame.push_back(OPT_END);
         end
         PLAN_NO_END: begin
            put_opt(OPT_MSGTYPE, 8'd1, 32'h0500_0000);
            put_opt(OPT_MASK, 8'd4, $urandom);
         end
         PLAN_CUT_DATA: begin
            // The lease option stops after two of its four bytes.
            put_opt(OPT_MSGTYPE, 8'd1, 32'h0200_0000);
            frame.push_back(OPT_LEASE);
            frame.push_back(8'd4);
            frame.push_back(8'($urandom));
            frame.push_back(8'($urandom));
         end
         PLAN_CUT_LEN: begin
            put_opt(OPT_MSGTYPE, 8'd1, 32'h0200_0000);
            frame.push_back(OPT_SERVER);
         end
         PLAN_ODD: begin
            frame.push_back(OPT_PAD);
            frame.push_back(OPT_PAD);
            put_opt(OPT_ROUTER, 8'd8, $urandom);
            put_opt(OPT_MASK, 8'd5, $urandom);
            put_opt(OPT_SERVER, 8'd3, $urandom);
            put_opt(OPT_LEASE, 8'd4, $urandom);
            put_opt(8'd200, 8'd0, 32'h0);
            put_opt(OPT_MSGTYPE, 8'd2, $urandom);
            put_opt(OPT_MSGTYPE, 8'd1, 32'h0700_0000);
            frame.push_back(OPT_END);
         end
         PLAN_REPEAT: begin
            put_opt(OPT_LEASE, 8'd4, $urandom);
            put_opt(OPT_LEASE, 8'd4, $urandom);
            put_opt(OPT_MSGTYPE, 8'd1, 32'h0300_0000);
            put_opt(OPT_MSGTYPE, 8'd1, 32'h0500_0000);
            put_opt(OPT_SERVER, 8'd4, $urandom);
            put_opt(OPT_SERVER, 8'd4, $urandom);
            frame.push_back(OPT_END);
         end
         default: begin
            repeat ($urandom_range(0, 6)) begin
               mt = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
               case ($urandom_range(0, 9))
                  0, 1: put_opt(OPT_MSGTYPE, 8'd1, {mt, 24'h0});
                  2: put_opt(OPT_MASK, 8'd4, $urandom);
                  3: put_opt(OPT_ROUTER, 8'($urandom_range(1, 12)), $urandom);
                  4: put_opt(OPT_SERVER, 8'd4, $urandom);
                  5: put_opt(OPT_LEASE, 8'd4, $urandom);
                  6: put_opt(8'($urandom_range(1, 254)), 8'($urandom_range(0, 6)), $urandom);
                  7: repeat ($urandom_range(1, 3)) frame.push_back(OPT_PAD);
                  8: put_opt(KNOWN_CODES[$urandom_range(0, 4)], 8'($urandom_range(0, 6)),
                             $urandom);
                  default: put_opt(OPT_MSGTYPE, 8'($urandom_range(0, 3)), {mt, 24'h0});
               endcase
            end
            if ($urandom_range(0, 7) != 0) frame.push_back(OPT_END);
         end
      endcase
   endfunction

   function automatic void trim_frame(int n);
      while (n > 0 && frame.size() > n) void'(frame.pop_back());
   endfunction

   // ---------------------------------------------------------------- driving

   // The sender works in bursts; a gap may precede each.
   task automatic send_byte(logic [7:0] b, logic fin);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, last_byte: fin};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
   endtask

   // Holds the sender off until every pending response has been taken.
   task automatic stop_sending();
      req_valid <= 1'b0;
      burst_left = 0;
      while (replies_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [47:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_CLIENT_MAC) cfg_mac = val;
      else cfg_xid = val[31:0];
      @(negedge clock);
   endtask

   initial begin
      take_mode_e  mode;
      logic [7:0]  pat;
      rsp_ready = 1'b0;
      forever begin
         mode = take_mode_e'($urandom_range(0, 2));
         pat  = 8'($urandom_range(1, 255));
         repeat ($urandom_range(20, 200)) begin
            @(negedge clock);
            case (mode)
               TAKE_ALL:  rsp_ready <= 1'b1;
               TAKE_COIN: rsp_ready <= 1'($urandom_range(0, 1));
               default: begin
                  rsp_ready <= pat[0];
                  pat = {pat[0], pat[7:1]};
               end
            endcase
         end
      end
   end

   initial begin
      int          r;
      int          phase_no;
      int          rand_bytes;
      int          rand_frames;
      logic [7:0]  op;
      logic [2:0]  bad;
      logic [47:0] mac;
      logic [31:0] xid;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_write  = 1'b0;
      csr_index  = CSR_CLIENT_MAC;
      csr_wdata  = '0;
      cfg_mac    = '0;
      cfg_xid    = XID_RESET;
      k_offer    = '0;
      k_router   = '0;
      k_mask     = '0;
      k_server   = '0;
      k_lease    = '0;
      row_typed  = 1'b0;
      row_want   = STATUS_OK;
      burst_left = 0;
      mismatches = 0;
      new_datagram();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed datagrams run on the register values left by reset.
      foreach (DIRECTED_ROWS[i]) begin
         row_typed = DIRECTED_ROWS[i].typed;
         row_want  = DIRECTED_ROWS[i].want;
         build_header(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].bad_xid,
                      DIRECTED_ROWS[i].bad_hw, DIRECTED_ROWS[i].bad_ck);
         add_plan(DIRECTED_ROWS[i].plan);
         repeat (DIRECTED_ROWS[i].tail) frame.push_back(8'($urandom));
         trim_frame(int'(DIRECTED_ROWS[i].cut));
         send_frame();
      end
      row_typed = 1'b0;

      phase_no    = 0;
      rand_bytes  = 0;
      rand_frames = 0;
      while (rand_bytes < 600 || rand_frames < 45) begin
         case (phase_no)
            0: begin
               mac = '0;
               xid = '0;
            end
            1: begin
               mac = '1;
               xid = '1;
            end
            default: begin
               mac = 48'({$urandom, $urandom});
               xid = $urandom;
            end
         endcase
         stop_sending();
         if (phase_no < 2 || $urandom_range(0, 2) != 0) write_reg(CSR_CLIENT_MAC, mac);
         if (phase_no < 2 || $urandom_range(0, 2) != 0) write_reg(CSR_XID, {16'h0, xid});
         repeat (12) begin
            if ($urandom_range(0, 19) == 0) stop_sending();
            r = $urandom_range(0, 99);
            if (r < 60) begin
               build_header(OP_REPLY, 1'b0, 1'b0, 1'b0);
               add_plan(PLAN_RANDOM);
               repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
               if ($urandom_range(0, 9) == 0) trim_frame($urandom_range(1, frame.size()));
            end else if (r < 85) begin
               op = OP_REPLY;
               if ($urandom_range(0, 3) == 0) begin
                  do op = 8'($urandom); while (op == OP_REPLY);
               end
               bad = 3'($urandom_range(0, 7));
               if (op == OP_REPLY && bad == 3'd0) bad = 3'($urandom_range(1, 7));
               build_header(op, bad[0], bad[1], bad[2]);
               add_plan(PLAN_RANDOM);
               if ($urandom_range(0, 1) == 0) trim_frame($urandom_range(1, frame.size()));
            end else begin
               frame.delete();
               repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom));
               if ($urandom_range(0, 9) < 3) frame[0] = OP_REPLY;
            end
            rand_bytes += frame.size();
            rand_frames++;
            send_frame();
         end
         phase_no++;
      end

      stop_sending();
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
